[hw/rtl/spdpi_pkg.sv]
// Package for the speed PI drive controller: payload structs, event kind codes,
// register indexes, controller state type and fixed field widths.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package spdpi_pkg;

  // Drive field width; the result struct follows it, so it is fixed here.
  localparam int DRIVE_BITS = 12;
  localparam int NUM_BITS   = 16;
  localparam int INT_BITS   = 23;
  localparam int ERR_BITS   = 15;
  localparam int PROD_BITS  = 25;

  localparam logic [2:0] KIND_CAPTURE = 3'd0;
  localparam logic [2:0] KIND_TIMEOUT = 3'd1;
  localparam logic [2:0] KIND_UP      = 3'd2;
  localparam logic [2:0] KIND_DOWN    = 3'd3;
  localparam logic [2:0] KIND_TICK    = 3'd4;

  localparam logic [2:0] REG_PROP_GAIN  = 3'd0;
  localparam logic [2:0] REG_INT_GAIN   = 3'd1;
  localparam logic [2:0] REG_NUMERATOR  = 3'd2;
  localparam logic [2:0] REG_SPEED_MIN  = 3'd3;
  localparam logic [2:0] REG_SPEED_MAX  = 3'd4;
  localparam logic [2:0] REG_IDLE_DRIVE = 3'd5;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] capture_value;
    logic        button_low;
  } spdpi_in_t;

  typedef struct packed {
    logic [DRIVE_BITS-1:0] drive;
    logic [15:0]           speed;
    logic                  speed_valid;
    logic signed [15:0]    target_speed;
  } spdpi_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_CHECK,
    ST_IMUL,
    ST_IACC,
    ST_PMUL,
    ST_PDRIVE,
    ST_DONE
  } spdpi_state_t;

endpackage

`default_nettype wire

[hw/rtl/speed_pi_drive_controller.sv]
// Speed PI drive controller top level: event intake, setpoint, integral and
// drive sequencing. Depends on spdpi_pkg and spdpi_div.
//
// Usage:
//   The item channel (item_valid/item_stall/item) carries capture, timeout,
//   button and control tick events. Capture, timeout and button events produce
//   no result. A control tick produces one result on the result channel
//   (result_valid/result_stall/result). A tick inside the speed window with a
//   non-negative error passes through the divide state, one window check, two
//   passes through the shared multiplier, each with an add and saturate, and
//   a load of the output register. The next event can transfer in the cycle
//   after that load. Other ticks skip the multiplier, or the divider too when
//   no period is stored. item_stall is high while a tick is in flight.
//   The result sits in an output register; while the receiver stalls it holds,
//   and events still transfer while no tick is in flight. A new tick result waits for
//   the register to empty.
//   Configuration writes on cfg_valid/cfg_index/cfg_data are always taken
//   (cfg_ready is high); indexes beyond the register list are ignored.
//   Reset (rst, synchronous) loads the register defaults, clears the period,
//   setpoint and integral, and empties the output register.
`timescale 1ns / 1ps
`default_nettype none

module speed_pi_drive_controller #(
  parameter int CAPTURE_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  item_valid,
  output logic                       item_stall,
  input  wire spdpi_pkg::spdpi_in_t  item,
  output logic                       result_valid,
  input  wire logic                  result_stall,
  output spdpi_pkg::spdpi_out_t      result,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [2:0]            cfg_index,
  input  wire logic [15:0]           cfg_data
);

  localparam int DB = spdpi_pkg::DRIVE_BITS;
  localparam int IB = spdpi_pkg::INT_BITS;
  localparam int EB = spdpi_pkg::ERR_BITS;
  localparam int PB = spdpi_pkg::PROD_BITS;

  logic [7:0]    prop_gain;
  logic [9:0]    int_gain_q10;
  logic [15:0]   speed_numerator;
  logic [15:0]   speed_min;
  logic [15:0]   speed_max;
  logic [DB-1:0] idle_drive;

  logic [CAPTURE_BITS-1:0] period_count;
  logic signed [15:0]      setpoint;
  logic [IB-1:0]           integral_q10;

  spdpi_pkg::spdpi_state_t state, state_next;

  logic          accept;
  logic          div_start;
  logic          div_done;
  logic [15:0]   quotient;
  logic [15:0]   speed_r;
  logic          valid_r;
  logic [DB-1:0] drive_r;
  logic [EB-1:0] err_mag;
  logic [PB-1:0] prod;
  logic [9:0]    mul_a;
  logic signed [17:0] err;
  logic          in_window;
  logic          out_free;
  logic [PB:0]   int_sum;
  logic [PB:0]   drive_sum;

  assign cfg_ready = 1'b1;
  assign accept    = item_valid && !item_stall;
  assign out_free  = !result_valid || !result_stall;
  assign err       = $signed({{2{setpoint[15]}}, setpoint}) - $signed({2'b00, speed_r});
  assign in_window = (speed_r >= speed_min) && (speed_r <= speed_max);
  assign int_sum   = (PB + 1)'(integral_q10) + (PB + 1)'(prod);
  assign drive_sum = (PB + 1)'(prod) + (PB + 1)'(integral_q10[IB-1:10]);

  spdpi_div #(
    .DIV_BITS (CAPTURE_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (speed_numerator),
    .divisor  (period_count),
    .quotient (quotient),
    .done     (div_done)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      spdpi_pkg::ST_IDLE: begin
        if (accept && item.kind == spdpi_pkg::KIND_TICK) begin
          state_next = (period_count != '0) ? spdpi_pkg::ST_DIV : spdpi_pkg::ST_DONE;
        end
      end
      spdpi_pkg::ST_DIV: begin
        if (div_done) state_next = spdpi_pkg::ST_CHECK;
      end
      spdpi_pkg::ST_CHECK: begin
        state_next = (in_window && !err[17]) ? spdpi_pkg::ST_IMUL : spdpi_pkg::ST_DONE;
      end
      spdpi_pkg::ST_IMUL:   state_next = spdpi_pkg::ST_IACC;
      spdpi_pkg::ST_IACC:   state_next = spdpi_pkg::ST_PMUL;
      spdpi_pkg::ST_PMUL:   state_next = spdpi_pkg::ST_PDRIVE;
      spdpi_pkg::ST_PDRIVE: state_next = spdpi_pkg::ST_DONE;
      spdpi_pkg::ST_DONE: begin
        if (out_free) state_next = spdpi_pkg::ST_IDLE;
      end
      default: state_next = spdpi_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    item_stall = (state != spdpi_pkg::ST_IDLE);
    div_start  = accept && (item.kind == spdpi_pkg::KIND_TICK) && (period_count != '0);
    mul_a      = (state == spdpi_pkg::ST_IMUL) ? int_gain_q10 : {2'b00, prop_gain};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= spdpi_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain       <= 8'd70;
      int_gain_q10    <= 10'd102;
      speed_numerator <= 16'd1696;
      speed_min       <= 16'd30;
      speed_max       <= 16'd150;
      idle_drive      <= DB'(1024);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        spdpi_pkg::REG_PROP_GAIN:  prop_gain       <= cfg_data[7:0];
        spdpi_pkg::REG_INT_GAIN:   int_gain_q10    <= cfg_data[9:0];
        spdpi_pkg::REG_NUMERATOR:  speed_numerator <= cfg_data;
        spdpi_pkg::REG_SPEED_MIN:  speed_min       <= cfg_data;
        spdpi_pkg::REG_SPEED_MAX:  speed_max       <= cfg_data;
        spdpi_pkg::REG_IDLE_DRIVE: idle_drive      <= cfg_data[DB-1:0];
        default: ;
      endcase
    end
  end

  // Event state: period, setpoint and integral.
  always_ff @(posedge clk) begin
    if (rst) begin
      period_count <= '0;
      setpoint     <= '0;
      integral_q10 <= '0;
    end else begin
      if (accept) begin
        case (item.kind)
          spdpi_pkg::KIND_CAPTURE: period_count <= CAPTURE_BITS'(item.capture_value);
          spdpi_pkg::KIND_TIMEOUT: period_count <= '0;
          spdpi_pkg::KIND_UP: begin
            if (item.button_low && setpoint != 16'sh7FFF) setpoint <= setpoint + 16'sd1;
          end
          spdpi_pkg::KIND_DOWN: begin
            if (item.button_low && setpoint != 16'sh8000) setpoint <= setpoint - 16'sd1;
          end
          default: ;
        endcase
      end
      if (state == spdpi_pkg::ST_IACC) begin
        integral_q10 <= (int_sum[PB:IB] != '0) ? {IB{1'b1}} : int_sum[IB-1:0];
      end
    end
  end

  // Datapath working registers; the multiplier is shared by both gain terms.
  always_ff @(posedge clk) begin
    if (accept && item.kind == spdpi_pkg::KIND_TICK) begin
      speed_r <= '0;
      valid_r <= (period_count != '0);
      drive_r <= idle_drive;
    end
    if (state == spdpi_pkg::ST_DIV && div_done) begin
      speed_r <= quotient;
    end
    if (state == spdpi_pkg::ST_CHECK) begin
      err_mag <= err[EB-1:0];
      if (in_window && err[17]) drive_r <= '0;
    end
    if (state == spdpi_pkg::ST_IMUL || state == spdpi_pkg::ST_PMUL) begin
      prod <= PB'(mul_a) * PB'(err_mag);
    end
    if (state == spdpi_pkg::ST_PDRIVE) begin
      drive_r <= (drive_sum[PB:DB] != '0) ? {DB{1'b1}} : drive_sum[DB-1:0];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == spdpi_pkg::ST_DONE && out_free) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == spdpi_pkg::ST_DONE && out_free) begin
      result.drive        <= drive_r;
      result.speed        <= speed_r;
      result.speed_valid  <= valid_r;
      result.target_speed <= setpoint;
    end
  end

  // The divider only finishes while the sequencer waits on it.
  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == spdpi_pkg::ST_DIV)
    else $error("divider finished outside the divide state");

  // A division is never run against an empty period.
  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == spdpi_pkg::ST_DIV |-> period_count != '0)
    else $error("divide started with zero period");

  // The integral only grows.
  a_integral_grows: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> integral_q10 >= $past(integral_q10))
    else $error("integral decreased");

  // An invalid speed is reported as zero.
  a_invalid_speed_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.speed_valid |-> result.speed == 16'd0)
    else $error("invalid speed with nonzero value");

endmodule

`default_nettype wire

[hw/rtl/spdpi_div.sv]
// Restoring serial divider: one quotient bit per cycle for a 16-bit dividend.
// Depends on spdpi_pkg for the dividend width.
`timescale 1ns / 1ps
`default_nettype none

module spdpi_div #(
  parameter int DIV_BITS = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  input  wire logic [spdpi_pkg::NUM_BITS-1:0]    dividend,
  input  wire logic [DIV_BITS-1:0]               divisor,
  output logic      [spdpi_pkg::NUM_BITS-1:0]    quotient,
  output logic                                   done
);

  localparam int NB       = spdpi_pkg::NUM_BITS;
  localparam int REM_BITS = ((DIV_BITS > NB) ? DIV_BITS : NB) + 1;
  localparam int CNT_BITS = $clog2(NB + 1);

  logic                busy;
  logic [CNT_BITS-1:0] cnt;
  logic [REM_BITS-1:0] rem;
  logic [REM_BITS-1:0] shifted;
  logic [REM_BITS-1:0] div_ext;
  logic                fits;

  // The remainder stays below the divisor, so below 2^DIV_BITS, and the top bit is free.
  assign shifted = {rem[REM_BITS-2:0], quotient[NB-1]};
  assign div_ext = REM_BITS'(divisor);
  assign fits    = (shifted >= div_ext);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_BITS'(NB);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
    end else if (busy) begin
      rem      <= fits ? (shifted - div_ext) : shifted;
      quotient <= {quotient[NB-2:0], fits};
    end
  end

endmodule

`default_nettype wire
